### rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8d_pkg
// Shared types and constants for the UTF-8 code point decoder.
// ============================================================================
package utf8d_pkg;

    localparam int BYTE_W   = 8;
    localparam int POINT_W  = 21;
    localparam int PEND_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Continuation-byte payload width.
    localparam int CONT_BITS = 6;

    // Lead byte prefixes, compared against the top bits of the byte.
    localparam logic [2:0] LEAD2_PREFIX = 3'b110;
    localparam logic [3:0] LEAD3_PREFIX = 4'b1110;
    localparam logic [4:0] LEAD4_PREFIX = 5'b11110;
    localparam logic [1:0] CONT_PREFIX  = 2'b10;

    // Remaining continuation counts set by each lead form.
    localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [POINT_W-1:0] point_t;

    // One decoded result word.
    typedef struct packed {
        logic   point_ready;
        point_t code_point;
        logic   text_done;
    } result_t;

endpackage

### rtl/utf8d_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8d_decode
// Sequence state and the single-pass per-byte decode logic.
// ============================================================================
module utf8d_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  utf8d_pkg::byte_t text_byte,
    input  logic             final_byte,
    output utf8d_pkg::result_t result
);
    import utf8d_pkg::*;

    logic [PEND_W-1:0] pending_reg, pending_next;
    point_t            partial_reg, partial_next;
    logic              good_reg, good_next;

    logic   is_cont;
    logic   ready;
    point_t cp;

    assign is_cont = (text_byte[7:6] == CONT_PREFIX);

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        good_next    = good_reg;
        ready        = 1'b0;
        cp           = '0;

        if (pending_reg == PEND_IDLE)
        begin
            if (!text_byte[7])
            begin
                ready = 1'b1;
                cp    = point_t'(text_byte);
            end
            else if (text_byte[7:5] == LEAD2_PREFIX)
            begin
                partial_next = point_t'(text_byte[4:0]);
                pending_next = PEND_ONE;
                good_next    = 1'b1;
            end
            else if (text_byte[7:4] == LEAD3_PREFIX)
            begin
                partial_next = point_t'(text_byte[3:0]);
                pending_next = PEND_TWO;
                good_next    = 1'b1;
            end
            else if (text_byte[7:3] == LEAD4_PREFIX)
            begin
                partial_next = point_t'(text_byte[2:0]);
                pending_next = PEND_THREE;
                good_next    = 1'b1;
            end
        end
        else
        begin
            if (good_reg)
            begin
                if (!is_cont)
                    good_next = 1'b0;
                else
                    partial_next = {partial_reg[POINT_W-CONT_BITS-1:0],
                                    text_byte[CONT_BITS-1:0]};
            end
            pending_next = pending_reg - PEND_ONE;
            if ((pending_next == PEND_IDLE) && good_next)
            begin
                ready = 1'b1;
                cp    = partial_next;
            end
        end

        // The end of the text drops any unfinished sequence.
        if (final_byte)
        begin
            pending_next = PEND_IDLE;
            partial_next = '0;
            good_next    = 1'b1;
        end
    end

    assign result.point_ready = ready;
    assign result.code_point  = cp;
    assign result.text_done   = final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PEND_IDLE;
            partial_reg <= '0;
            good_reg    <= 1'b1;
        end
        else if (advance)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            good_reg    <= good_next;
        end
    end

endmodule

### rtl/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// utf8_codepoint_decoder
// Decodes a UTF-8 byte stream into code points, one result word per byte.
// ============================================================================
//
//  Channel | Direction | tdata                 | tuser        | tlast
//  --------+-----------+-----------------------+--------------+-----------
//  s_*     | in        | [7:0] text_byte       | -            | final_byte
//  m_*     | out       | [20:0] code_point     | point_ready  | text_done
//
// Each input word is taken into an input register, decoded in one pass of
// logic against the sequence state, and written into the result register.
// The block accepts one word per cycle while the output is not stalled;
// the input and result registers form a two-deep pipeline.
// A stall on the output side holds the result register and, once both
// stages are full, drops s_tready. Reset clears the valid flags and returns
// the decoder to idle with no sequence pending.
//
module utf8_codepoint_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream: tdata [7:0] text_byte; tlast carries final_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [utf8d_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic        s_tlast,
    // Output stream: tdata [20:0] code_point, [23:21] zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [utf8d_pkg::OUT_TDATA_W-1:0] m_tdata,
    // tuser [0] point_ready.
    output logic        m_tuser,
    output logic        m_tlast
);
    import utf8d_pkg::*;

    // Input register stage.
    logic    in_valid_reg;
    byte_t   in_byte_reg;
    logic    in_final_reg;

    // Result register stage.
    logic    out_valid_reg;
    result_t out_reg;

    result_t decoded;
    logic    advance;
    logic    s_accept;

    // The decode stage moves forward whenever it holds a word and the
    // result register is empty or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    utf8d_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .text_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .result     (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_final_reg <= s_tlast;
        end
        if (advance)
            out_reg <= decoded;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-POINT_W){1'b0}}, out_reg.code_point};
    assign m_tuser  = out_reg.point_ready;
    assign m_tlast  = out_reg.text_done;

endmodule

### tb/tb_utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_utf8_codepoint_decoder
// Self-checking bench for the UTF-8 code point decoder. Texts are streamed
// into the block one byte per word, and a bit-accurate decoder model
// predicts the result word for each accepted byte. The monitor compares
// every result word with the oldest prediction. Directed texts cover the
// field extremes and the error cases. Random texts, mostly well formed,
// then run under several sender idle and receiver stall mixes and under
// one long output hold-off.
// ============================================================================
module tb_utf8_codepoint_decoder;

    import utf8d_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_REPORTS  = 40;
    localparam int PHASE_BYTES  = 450;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;

    // Model copy of the decoder state.
    logic [PEND_W-1:0] model_pending;
    point_t            model_partial;
    logic              model_good;

    result_t expected_words[$];
    byte_t   text_buf[$];

    int idle_pct;
    int stall_pct;
    int hold_left;
    int bytes_sent;
    int error_count;
    int cycle_count;

    utf8_codepoint_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Advances the decoder model by one byte and returns the word it owes.
    function automatic result_t decode_byte(input byte_t b, input logic fin);
        result_t r;
        r = '0;
        if (model_pending == PEND_IDLE)
        begin
            if (b[7] == 1'b0)
            begin
                r.point_ready = 1'b1;
                r.code_point  = point_t'(b);
            end
            else if (b[7:5] == LEAD2_PREFIX)
            begin
                model_partial = point_t'(b[4:0]);
                model_pending = PEND_ONE;
                model_good    = 1'b1;
            end
            else if (b[7:4] == LEAD3_PREFIX)
            begin
                model_partial = point_t'(b[3:0]);
                model_pending = PEND_TWO;
                model_good    = 1'b1;
            end
            else if (b[7:3] == LEAD4_PREFIX)
            begin
                model_partial = point_t'(b[2:0]);
                model_pending = PEND_THREE;
                model_good    = 1'b1;
            end
            // Anything else is a stray continuation or an invalid lead: skipped.
        end
        else
        begin
            // Once a sequence has gone bad its remaining bytes are only counted.
            if (model_good)
            begin
                if (b[7:6] != CONT_PREFIX)
                    model_good = 1'b0;
                else
                    model_partial = {model_partial[POINT_W-CONT_BITS-1:0], b[5:0]};
            end
            model_pending = model_pending - 1'b1;
            if (model_pending == PEND_IDLE && model_good)
            begin
                r.point_ready = 1'b1;
                r.code_point  = model_partial;
            end
        end
        if (fin)
        begin
            model_pending = PEND_IDLE;
            model_partial = '0;
            model_good    = 1'b1;
        end
        r.text_done = fin;
        return r;
    endfunction

    // Receiver side: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor.
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected word: ready=%0b point=%h last=%0b",
                                 $time, m_tuser, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.point_ready ||
                        m_tdata !== {{(OUT_TDATA_W-POINT_W){1'b0}}, want.code_point} ||
                        m_tlast !== want.text_done)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("%0t: mismatch: exp %0b %h %0b, got %0b %h %0b",
                                     $time, want.point_ready, want.code_point,
                                     want.text_done, m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // Offers one byte, after a random idle gap, and waits for it to be taken.
    // Called and returns at a falling edge.
    task automatic send_byte(input byte_t b, input logic fin);
        int gap;
        begin
            gap = 0;
            while (gap < 40 && $urandom_range(99) < idle_pct)
                gap++;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            s_tlast  <= fin;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            expected_words.insert(expected_words.size(), decode_byte(b, fin));
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    // Streams text_buf with the final flag on its last byte.
    task automatic send_text();
        begin
            for (int i = 0; i < text_buf.size(); i++)
                send_byte(text_buf[i], i == text_buf.size() - 1);
        end
    endtask

    // Sender stops and waits until every predicted word has come back.
    task automatic wait_drained();
        begin
            s_tvalid <= 1'b0;
            while (expected_words.size() != 0)
                @(negedge clk);
            repeat (8) @(negedge clk);
        end
    endtask

    // Adds one byte to the end of the text being built.
    task automatic append_byte(input byte_t b);
        begin
            text_buf.insert(text_buf.size(), b);
        end
    endtask

    function automatic byte_t cont_byte();
        logic [5:0] low;
        low = 6'($urandom_range(63));
        return {CONT_PREFIX, low};
    endfunction

    // Lead byte for a sequence of len bytes, with random payload bits.
    function automatic byte_t lead_byte(input int len);
        byte_t r;
        r = byte_t'($urandom_range(255));
        case (len)
            2: r[7:5] = LEAD2_PREFIX;
            3: r[7:4] = LEAD3_PREFIX;
            4: r[7:3] = LEAD4_PREFIX;
            default: r[7] = 1'b0;
        endcase
        return r;
    endfunction

    // Random text: mostly well-formed characters, some noise bytes and some
    // broken sequences (bad or missing continuations).
    task automatic build_random_text();
        int chars;
        int kind;
        int len;
        int conts;
        int bad_at;
        begin
            text_buf.delete();
            chars = $urandom_range(10, 1);
            for (int c = 0; c < chars; c++)
            begin
                kind = $urandom_range(99);
                if (kind < 30)
                    append_byte(lead_byte(1));
                else if (kind < 82)
                begin
                    len = (kind < 50) ? 2 : (kind < 66) ? 3 : 4;
                    append_byte(lead_byte(len));
                    for (int k = 1; k < len; k++)
                        append_byte(cont_byte());
                end
                else if (kind < 90)
                    append_byte(byte_t'($urandom_range(255)));
                else
                begin
                    len    = $urandom_range(4, 2);
                    conts  = $urandom_range(len - 1);
                    bad_at = ($urandom_range(1) == 1) ? $urandom_range(len - 1) : len;
                    append_byte(lead_byte(len));
                    for (int k = 1; k <= conts; k++)
                        append_byte((k == bad_at) ? byte_t'($urandom_range(255))
                                                  : cont_byte());
                end
            end
        end
    endtask

    task automatic test_ascii_extremes();
        begin
            text_buf = '{8'h00, 8'h7F};
            send_text();
        end
    endtask

    // Sequences of two, three and four bytes, then a second four-byte one giving the largest code point.
    task automatic test_sequence_lengths();
        begin
            text_buf = '{8'hC2, 8'hA9, 8'hEF, 8'hBF, 8'hBF,
                         8'hF0, 8'h9F, 8'h98, 8'h80,
                         8'hF7, 8'hBF, 8'hBF, 8'hBF};
            send_text();
        end
    endtask

    // Stray continuation, five-byte lead and all-ones byte while idle.
    task automatic test_invalid_leads();
        begin
            text_buf = '{8'h80, 8'hF8, 8'hFF};
            send_text();
        end
    endtask

    // The bad second byte spoils the sequence; the lead byte that follows is
    // still counted as its third byte, so only the trailing 'A' decodes.
    task automatic test_bad_continuation();
        begin
            text_buf = '{8'hE2, 8'h41, 8'hC3, 8'h41};
            send_text();
        end
    endtask

    task automatic test_cut_short();
        begin
            text_buf = '{8'hF0, 8'h9F};
            send_text();
        end
    endtask

    task automatic test_random_texts(input int idle, input int stall, input int count);
        int stop_at;
        begin
            idle_pct  = idle;
            stall_pct = stall;
            stop_at   = bytes_sent + count;
            while (bytes_sent < stop_at)
            begin
                build_random_text();
                send_text();
            end
            wait_drained();
        end
    endtask

    // The receiver holds off while the sender keeps offering at full rate,
    // so the pipeline fills and the input side has to stall.
    task automatic test_output_hold();
        int stop_at;
        begin
            idle_pct  = 0;
            stall_pct = 0;
            hold_left = 120;
            stop_at   = bytes_sent + 60;
            while (bytes_sent < stop_at)
            begin
                build_random_text();
                send_text();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = 0;
        bytes_sent  = 0;
        error_count = 0;
        model_pending = PEND_IDLE;
        model_partial = '0;
        model_good    = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ascii_extremes();
        test_sequence_lengths();
        test_invalid_leads();
        test_bad_continuation();
        test_cut_short();
        wait_drained();

        test_random_texts(0, 0, PHASE_BYTES);
        test_random_texts(52, 0, PHASE_BYTES);
        test_random_texts(0, 52, PHASE_BYTES);
        test_random_texts(29, 29, PHASE_BYTES);
        test_output_hold();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
